### hw/rtl/sgpa_pkg.sv
package sgpa_pkg;

   // Field and datapath widths.
   localparam int unsigned POS_W  = 32;
   localparam int unsigned ACC_W  = 64;
   localparam int unsigned CSR_AW = 8;
   localparam int unsigned SEP_W  = POS_W + 2;
   localparam int unsigned MAG_W  = POS_W + 1;
   localparam int unsigned R2_W   = 52;
   localparam int unsigned PROD_W = 2 * MAG_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_AW-1:0] CSR_SOFTENING_SQ = 8'd0;
   localparam logic [CSR_AW-1:0] CSR_SHIFT_X      = 8'd1;
   localparam logic [CSR_AW-1:0] CSR_SHIFT_Y      = 8'd2;
   localparam logic [CSR_AW-1:0] CSR_SHIFT_Z      = 8'd3;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ADD,
      ST_NORM,
      ST_SQRT,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   // Steps of the product chain that follows the reciprocal.
   typedef enum logic [2:0] {
      OP_POT,
      OP_P2,
      OP_P3,
      OP_AX,
      OP_AY,
      OP_AZ
   } op_type;

endpackage

### hw/rtl/softened_gravity_pair_accumulator.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  sink, source, mass, first and last flags
// rsp_      out        rsp_valid/rsp_ready  acceleration, potential, saturated flag
// csr_      in         csr_we               csr_index, csr_wdata
//
// A pair runs from acceptance to the next ready through the squared distance, the
// normalising, the square root, the division, the six products and the emit step, on
// one shared 33 x 33 multiplier. A pair at zero distance goes from normalising
// straight to the emit step. Reset clears the configuration, the accumulators
// and the sequencer. A new transaction is taken once the previous pair is finished; a
// waiting result only holds the sequencer when the next total is ready to be written out.
module softened_gravity_pair_accumulator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [sgpa_pkg::CSR_AW-1:0]          csr_index,
   input  logic [sgpa_pkg::POS_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sgpa_pkg::POS_W-1:0]    req_sink_x,
   input  logic signed [sgpa_pkg::POS_W-1:0]    req_sink_y,
   input  logic signed [sgpa_pkg::POS_W-1:0]    req_sink_z,
   input  logic signed [sgpa_pkg::POS_W-1:0]    req_source_x,
   input  logic signed [sgpa_pkg::POS_W-1:0]    req_source_y,
   input  logic signed [sgpa_pkg::POS_W-1:0]    req_source_z,
   input  logic [sgpa_pkg::POS_W-1:0]           req_source_mass,
   input  logic                                 req_first_of_sink,
   input  logic                                 req_last_of_sink,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sgpa_pkg::ACC_W-1:0]    rsp_accel_x,
   output logic signed [sgpa_pkg::ACC_W-1:0]    rsp_accel_y,
   output logic signed [sgpa_pkg::ACC_W-1:0]    rsp_accel_z,
   output logic signed [sgpa_pkg::ACC_W-1:0]    rsp_potential,
   output logic                                 rsp_saturated
);
   import sgpa_pkg::*;

   localparam logic [63:0] SQRT_BIT0 = 64'h1000_0000_0000_0000;
   localparam logic [MAG_W-1:0] DIV_REM0 = 33'h0_2000_0000;
   localparam logic [63:0] TERM_CAP = 64'h8000_0000_0000_0000;
   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [POS_W-1:0]     soft_ff, soft_in;
   logic [POS_W-1:0]     shx_ff, shx_in, shy_ff, shy_in, shz_ff, shz_in;
   logic [MAG_W-1:0]     mag_ff [3];
   logic [MAG_W-1:0]     mag_in [3];
   logic [2:0]           neg_ff, neg_in;
   logic [POS_W-1:0]     mass_ff, mass_in;
   logic                 last_ff, last_in;
   logic [R2_W-1:0]      r2_ff, r2_in;
   logic [63:0]          norm_ff, norm_in;
   logic [4:0]           eh_ff, eh_in;
   logic [63:0]          x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [MAG_W-1:0]     rem_ff, rem_in, mant_ff, mant_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [31:0]          p_ff, p_in;
   logic [ACC_W-1:0]     acc_ff [4];
   logic [ACC_W-1:0]     acc_in [4];
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]     rax_ff, rax_in, ray_ff, ray_in, raz_ff, raz_in, rpot_ff, rpot_in;
   logic                 rsat_ff, rsat_in;

   logic [SEP_W-1:0]     sep [3];
   logic [MAG_W-1:0]     sep_mag [3];
   logic [MAG_W-1:0]     mul_a, mul_b, mag_sel;
   logic [PROD_W-1:0]    mul_p;
   logic [R2_W-1:0]      r2_sum;
   logic [63:0]          sq_try;
   logic [MAG_W-1:0]     rem_sh;
   logic [6:0]           shamt;
   logic [PROD_W+15:0]   shifted;
   logic                 term_sat;
   logic [63:0]          term;
   logic [1:0]           acc_idx;
   logic                 acc_up;
   logic [ACC_W+1:0]     acc_sum;
   logic [ACC_W-1:0]     acc_new;
   logic                 acc_ovf;

   // Separation of one axis, exact in two extra bits.
   function automatic logic [SEP_W-1:0] separation(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b,
                                                   input logic [POS_W-1:0] c);
      logic [SEP_W-1:0] r;
      r = {{2{a[POS_W-1]}}, a} - {{2{b[POS_W-1]}}, b} + {{2{c[POS_W-1]}}, c};
      return r;
   endfunction

   // Separations and their magnitudes, taken with the transaction.
   always_comb begin
      sep[0] = separation(req_sink_x, req_source_x, shx_ff);
      sep[1] = separation(req_sink_y, req_source_y, shy_ff);
      sep[2] = separation(req_sink_z, req_source_z, shz_ff);
      for (int i = 0; i < 3; i++) begin
         if (sep[i][SEP_W-1]) begin
            sep_mag[i] = MAG_W'(SEP_W'(0) - sep[i]);
         end else begin
            sep_mag[i] = sep[i][MAG_W-1:0];
         end
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff == ST_SQ_MUL ? cnt_ff[1:0] : 2'(op_ff - OP_AX))
         2'd0:    mag_sel = mag_ff[0];
         2'd1:    mag_sel = mag_ff[1];
         default: mag_sel = mag_ff[2];
      endcase
      if (state_ff == ST_SQ_MUL) begin
         mul_a = mag_sel;
         mul_b = mag_sel;
      end else if (op_ff == OP_POT) begin
         mul_a = mant_ff;
         mul_b = {1'b0, mass_ff};
      end else if (op_ff == OP_P2 || op_ff == OP_P3) begin
         mul_a = mant_ff;
         mul_b = {1'b0, p_ff};
      end else begin
         mul_a = {1'b0, p_ff};
         mul_b = mag_sel;
      end
      mul_p = mul_a * mul_b;
   end

   // Scaling of a product by a power of two, held at the term cap.
   always_comb begin
      if (op_ff == OP_POT) begin
         shamt = 7'd62 - {2'b00, eh_ff};
      end else begin
         shamt = 7'd90 - ({2'b00, eh_ff} + {1'b0, eh_ff, 1'b0});
      end
      shifted  = {prod_ff, 16'h0000} >> shamt;
      term_sat = (|shifted[PROD_W+15:64]) || (shifted[63] && (|shifted[62:0]));
      term     = term_sat ? TERM_CAP : shifted[63:0];
   end

   // Saturating accumulate into the selected total.
   always_comb begin
      if (op_ff == OP_POT) begin
         acc_idx = 2'd3;
         acc_up  = 1'b0;
      end else begin
         acc_idx = 2'(op_ff - OP_AX);
         case (acc_idx)
            2'd0:    acc_up = neg_ff[0];
            2'd1:    acc_up = neg_ff[1];
            default: acc_up = neg_ff[2];
         endcase
      end
      if (acc_up) begin
         acc_sum = {{2{acc_ff[acc_idx][ACC_W-1]}}, acc_ff[acc_idx]} + {2'b00, term};
      end else begin
         acc_sum = {{2{acc_ff[acc_idx][ACC_W-1]}}, acc_ff[acc_idx]} - {2'b00, term};
      end
      acc_ovf = !(acc_sum[ACC_W+1:ACC_W-1] == 3'b000 || acc_sum[ACC_W+1:ACC_W-1] == 3'b111);
      if (acc_ovf) begin
         acc_new = acc_sum[ACC_W+1] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_new = acc_sum[ACC_W-1:0];
      end
   end

   // Sequencer: next state and the datapath registers.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      soft_in      = soft_ff;
      shx_in       = shx_ff;
      shy_in       = shy_ff;
      shz_in       = shz_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mass_in      = mass_ff;
      last_in      = last_ff;
      r2_in        = r2_ff;
      norm_in      = norm_ff;
      eh_in        = eh_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      mant_in      = mant_ff;
      prod_in      = prod_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rax_in       = rax_ff;
      ray_in       = ray_ff;
      raz_in       = raz_ff;
      rpot_in      = rpot_ff;
      rsat_in      = rsat_ff;
      req_ready    = 1'b0;
      r2_sum       = r2_ff + {2'b00, prod_ff[PROD_W-1:16]};
      sq_try       = res_ff + bit_ff;
      rem_sh       = {rem_ff[MAG_W-2:0], 1'b0};

      // Configuration writes; unknown indexes are ignored.
      if (csr_we) begin
         unique case (csr_index)
            CSR_SOFTENING_SQ: soft_in = csr_wdata;
            CSR_SHIFT_X:      shx_in  = csr_wdata;
            CSR_SHIFT_Y:      shy_in  = csr_wdata;
            CSR_SHIFT_Z:      shz_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = sep_mag[i];
                  neg_in[i] = sep[i][SEP_W-1];
               end
               mass_in = req_source_mass;
               last_in = req_last_of_sink;
               r2_in   = {{(R2_W-POS_W){1'b0}}, soft_ff};
               cnt_in  = '0;
               if (req_first_of_sink) begin
                  for (int i = 0; i < 4; i++) begin
                     acc_in[i] = '0;
                  end
                  ovf_in = 1'b0;
               end
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            prod_in  = mul_p;
            state_in = ST_SQ_ADD;
         end
         ST_SQ_ADD: begin
            r2_in = r2_sum;
            if (cnt_ff == 6'd2) begin
               norm_in  = {{(64-R2_W){1'b0}}, r2_sum};
               eh_in    = '0;
               state_in = ST_NORM;
            end else begin
               cnt_in   = cnt_ff + 6'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_NORM: begin
            // Scale by even powers of two until the word reaches 2^60; a zero word goes to emit.
            if (norm_ff == '0) begin
               state_in = ST_EMIT;
            end else if (norm_ff[63:54] == '0) begin
               norm_in = norm_ff << 8;
               eh_in   = eh_ff + 5'd4;
            end else if (norm_ff[63:60] == '0) begin
               norm_in = norm_ff << 2;
               eh_in   = eh_ff + 5'd1;
            end else begin
               x_in     = norm_ff;
               res_in   = '0;
               bit_in   = SQRT_BIT0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // One result bit of the integer square root per cycle.
            if (x_ff >= sq_try) begin
               x_in   = x_ff - sq_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               rem_in   = DIV_REM0;
               mant_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division of 2^62 by the root, one quotient bit a cycle.
            if (rem_sh >= res_ff[MAG_W-1:0]) begin
               rem_in  = rem_sh - res_ff[MAG_W-1:0];
               mant_in = {mant_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               mant_in = {mant_ff[MAG_W-2:0], 1'b0};
            end
            if (cnt_ff == 6'd32) begin
               op_in    = OP_POT;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            case (op_ff) inside
               OP_P2, OP_P3: begin
                  p_in = prod_ff[63:32];
               end
               default: begin
                  if (op_ff == OP_POT) begin
                     p_in = prod_ff[63:32];
                  end
                  acc_in[acc_idx] = acc_new;
                  if (acc_ovf || term_sat) begin
                     ovf_in = 1'b1;
                  end
               end
            endcase
            if (op_ff == OP_AZ) begin
               state_in = ST_EMIT;
            end else begin
               op_in    = op_type'(op_ff + 3'd1);
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rax_in       = acc_ff[0];
               ray_in       = acc_ff[1];
               raz_in       = acc_ff[2];
               rpot_in      = acc_ff[3];
               rsat_in      = ovf_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_POT;
         cnt_ff       <= '0;
         soft_ff      <= '0;
         shx_ff       <= '0;
         shy_ff       <= '0;
         shz_ff       <= '0;
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= '0;
         end
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         soft_ff      <= soft_in;
         shx_ff       <= shx_in;
         shy_ff       <= shy_in;
         shz_ff       <= shz_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload.
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      mass_ff <= mass_in;
      last_ff <= last_in;
      r2_ff   <= r2_in;
      norm_ff <= norm_in;
      eh_ff   <= eh_in;
      x_ff    <= x_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      mant_ff <= mant_in;
      prod_ff <= prod_in;
      p_ff    <= p_in;
      rax_ff  <= rax_in;
      ray_ff  <= ray_in;
      raz_ff  <= raz_in;
      rpot_ff <= rpot_in;
      rsat_ff <= rsat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accel_x   = rax_ff;
   assign rsp_accel_y   = ray_ff;
   assign rsp_accel_z   = raz_ff;
   assign rsp_potential = rpot_ff;
   assign rsp_saturated = rsat_ff;

   // An accepted transaction always starts the distance squares.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SQ_MUL)
      else $error("accepted transaction did not start the sequencer");

   // The normalised word stays below 2^62 throughout the square root.
   a_sqrt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> x_ff[63:62] == 2'b00)
      else $error("square root operand out of range");

   // The root that divides 2^62 lies in [2^30, 2^31).
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (res_ff[63:31] == '0 && res_ff[30]))
      else $error("root out of range during division");

   // A result only appears from the emit step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit step");

endmodule

### bench/softened_gravity_pair_accumulator_test.sv
`timescale 1ns / 1ps

module softened_gravity_pair_accumulator_test;
   import sgpa_pkg::*;

   localparam logic [CSR_AW-1:0] CSR_UNUSED  = 8'd9;
   localparam logic [63:0]       TERM_LIMIT  = 64'h8000_0000_0000_0000;
   localparam int                STALL_LIMIT = 5000;
   localparam int                DRAIN_CYCLES = 200;

   typedef struct {
      logic signed [31:0] sink [3];
      logic signed [31:0] source [3];
      logic [31:0]        mass;
      logic               first;
      logic               last;
   } pair_type;

   typedef struct {
      logic [63:0] accel [3];
      logic [63:0] potential;
      logic        saturated;
   } totals_type;

   // Predicts the sink totals and checks them against the block's results.
   class gravity_scoreboard_type;
      logic [63:0] softening;
      logic [63:0] shift [3];
      logic [63:0] sum_accel [3];
      logic [63:0] sum_potential;
      bit          overflow_seen;
      bit          clipped;
      totals_type  pending_totals [$];
      int          mismatches;
      int          pairs_seen;
      int          totals_checked;
      int          saturated_seen;

      function new();
         softening = 0;
         for (int i = 0; i < 3; i++) begin
            shift[i] = 0;
            sum_accel[i] = 0;
         end
         sum_potential = 0;
         overflow_seen = 0;
         mismatches = 0;
         pairs_seen = 0;
         totals_checked = 0;
         saturated_seen = 0;
      endfunction

      function void set_register(logic [CSR_AW-1:0] index, logic [31:0] value);
         case (index)
            CSR_SOFTENING_SQ: softening = {32'd0, value};
            CSR_SHIFT_X:      shift[0] = 64'(signed'(value));
            CSR_SHIFT_Y:      shift[1] = 64'(signed'(value));
            CSR_SHIFT_Z:      shift[2] = 64'(signed'(value));
            default: ;
         endcase
      endfunction

      function logic [63:0] root_floor(logic [63:0] x);
         logic [63:0] res;
         logic [63:0] bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > x) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (x >= res + bit_v) begin
               x = x - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return res;
      endfunction

      // floor(a * b * 2^e), held at 2^63 when larger.
      function logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int e);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         if (e < 0) begin
            p = (-e >= 128) ? 128'd0 : p >> (-e);
         end else if (e > 0) begin
            if ((p >> (64 - e)) != 0) begin
               clipped = 1;
               return TERM_LIMIT;
            end
            p = p << e;
         end
         if (p > {64'd0, TERM_LIMIT}) begin
            clipped = 1;
            return TERM_LIMIT;
         end
         return p[63:0];
      endfunction

      // Saturating signed add of a signed magnitude, worked in offset binary.
      function void accumulate(inout logic [63:0] acc, input bit up, input logic [63:0] mag);
         logic [63:0] b;
         b = acc ^ TERM_LIMIT;
         if (up) begin
            if (mag > 64'hFFFF_FFFF_FFFF_FFFF - b) begin
               b = 64'hFFFF_FFFF_FFFF_FFFF;
               overflow_seen = 1;
            end else begin
               b = b + mag;
            end
         end else begin
            if (mag > b) begin
               b = 0;
               overflow_seen = 1;
            end else begin
               b = b - mag;
            end
         end
         acc = b ^ TERM_LIMIT;
      endfunction

      function void note_pair(pair_type p);
         logic [63:0]  dr;
         logic [63:0]  mag [3];
         bit           neg [3];
         logic [127:0] sq;
         logic [63:0]  r2;
         logic [63:0]  norm;
         logic [63:0]  mant;
         logic [63:0]  m;
         logic [63:0]  p1;
         logic [63:0]  p2;
         logic [63:0]  p3;
         logic [63:0]  term;
         int           n;
         int           eh;
         totals_type   t;
         pairs_seen++;
         if (p.first) begin
            for (int i = 0; i < 3; i++) sum_accel[i] = 0;
            sum_potential = 0;
            overflow_seen = 0;
         end
         // Squared separation in Q.16, softening included.
         r2 = softening;
         for (int i = 0; i < 3; i++) begin
            dr = 64'(p.sink[i]) - 64'(p.source[i]) + shift[i];
            neg[i] = dr[63];
            mag[i] = neg[i] ? -dr : dr;
            if (mag[i] > 64'h1_FFFF_FFFF) mag[i] = 64'h1_FFFF_FFFF;
            sq = {64'd0, mag[i]} * {64'd0, mag[i]};
            r2 = r2 + 64'(sq >> 16);
         end
         // A coincident pair with no softening contributes nothing.
         if (r2 != 0) begin
            clipped = 0;
            n = 0;
            norm = r2;
            while (norm < (64'd1 << 60)) begin
               norm = norm << 2;
               n += 2;
            end
            mant = (64'd1 << 62) / root_floor(norm);
            eh = n / 2;
            m = {32'd0, p.mass};
            term = scaled_product(m, mant, eh - 46);
            accumulate(sum_potential, 0, term);
            p1 = scaled_product(m, mant, -32);
            p2 = scaled_product(p1, mant, -32);
            p3 = scaled_product(p2, mant, -32);
            for (int i = 0; i < 3; i++) begin
               term = scaled_product(p3, mag[i], 3 * eh - 74);
               accumulate(sum_accel[i], neg[i], term);
            end
            if (clipped) overflow_seen = 1;
         end
         if (p.last) begin
            for (int i = 0; i < 3; i++) t.accel[i] = sum_accel[i];
            t.potential = sum_potential;
            t.saturated = overflow_seen;
            pending_totals.push_back(t);
         end
      endfunction

      function void compare_field(string field, logic [63:0] expected, logic [63:0] actual,
                                  ref bit bad);
         if (expected !== actual) begin
            bad = 1;
            mismatches++;
            if (mismatches <= 10)
               $display("  %s: expected %h, got %h", field, expected, actual);
         end
      endfunction

      function void check_totals(totals_type got);
         totals_type want;
         bit         bad;
         bad = 0;
         if (pending_totals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with no pending sink totals at %0t", $realtime);
            return;
         end
         want = pending_totals.pop_front();
         totals_checked++;
         if (got.saturated) saturated_seen++;
         compare_field("accel_x", want.accel[0], got.accel[0], bad);
         compare_field("accel_y", want.accel[1], got.accel[1], bad);
         compare_field("accel_z", want.accel[2], got.accel[2], bad);
         compare_field("potential", want.potential, got.potential, bad);
         compare_field("saturated", 64'(want.saturated), 64'(got.saturated), bad);
         if (bad && mismatches <= 10)
            $display("ERROR: sink totals %0d differ at %0t", totals_checked, $realtime);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_index;
   logic [31:0]       csr_wdata;
   logic              req_valid;
   logic              req_ready;
   logic signed [31:0] req_sink_x, req_sink_y, req_sink_z;
   logic signed [31:0] req_source_x, req_source_y, req_source_z;
   logic [31:0]       req_source_mass;
   logic              req_first_of_sink;
   logic              req_last_of_sink;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [63:0] rsp_accel_x, rsp_accel_y, rsp_accel_z, rsp_potential;
   logic              rsp_saturated;

   gravity_scoreboard_type board;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                quiet_cycles;

   softened_gravity_pair_accumulator u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sink_x        (req_sink_x),
      .req_sink_y        (req_sink_y),
      .req_sink_z        (req_sink_z),
      .req_source_x      (req_source_x),
      .req_source_y      (req_source_y),
      .req_source_z      (req_source_z),
      .req_source_mass   (req_source_mass),
      .req_first_of_sink (req_first_of_sink),
      .req_last_of_sink  (req_last_of_sink),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accel_x       (rsp_accel_x),
      .rsp_accel_y       (rsp_accel_y),
      .rsp_accel_z       (rsp_accel_z),
      .rsp_potential     (rsp_potential),
      .rsp_saturated     (rsp_saturated)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Receiver: stalls at random and checks every accepted result.
   initial begin
      totals_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.accel[0] = rsp_accel_x;
            got.accel[1] = rsp_accel_y;
            got.accel[2] = rsp_accel_z;
            got.potential = rsp_potential;
            got.saturated = rsp_saturated;
            board.check_totals(got);
         end
      end
   end

   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d quiet cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // All driving tasks start and end just after a falling edge.
   task automatic write_register(logic [CSR_AW-1:0] index, logic [31:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      board.set_register(index, value);
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   task automatic send_pair(pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_sink_x <= p.sink[0];
      req_sink_y <= p.sink[1];
      req_sink_z <= p.sink[2];
      req_source_x <= p.source[0];
      req_source_y <= p.source[1];
      req_source_z <= p.source[2];
      req_source_mass <= p.mass;
      req_first_of_sink <= p.first;
      req_last_of_sink <= p.last;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      board.note_pair(p);
      @(negedge clock);
   endtask

   // Wait for every pending total, then for any pair still in flight without one.
   task automatic drain();
      req_valid <= 0;
      while (board.pending_totals.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord(int style);
      case (style)
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152)) - 1048576);
         default: return 32'($signed($urandom_range(512)) - 256);
      endcase
   endfunction

   function automatic logic [31:0] random_mass();
      case ($urandom_range(5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(32'h0100_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_simple(logic [31:0] sink, logic [31:0] source, logic [31:0] mass,
                              logic first, logic last);
      pair_type p;
      for (int i = 0; i < 3; i++) begin
         p.sink[i] = sink;
         p.source[i] = source;
      end
      p.source[1] = (source == sink) ? source : 32'd0;
      p.mass = mass;
      p.first = first;
      p.last = last;
      send_pair(p);
   endtask

   // Random sinks, mostly well-formed first..last groups with some loose flags.
   task automatic random_sinks(int count);
      pair_type p;
      int    sent;
      int    len;
      int    style;
      bit    loose;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 6);
         style = $urandom_range(2);
         loose = ($urandom_range(9) == 0);
         for (int i = 0; i < 3; i++) p.sink[i] = random_coord(style);
         for (int j = 0; j < len; j++) begin
            for (int i = 0; i < 3; i++)
               p.source[i] = ($urandom_range(19) == 0) ? p.sink[i]
                                                       : p.sink[i] + random_coord(style);
            p.mass = random_mass();
            p.first = loose ? 1'($urandom) : (j == 0);
            p.last = loose ? 1'($urandom) : (j == len - 1);
            send_pair(p);
            sent++;
         end
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = 0;
      req_valid = 0;
      req_sink_x = 0;
      req_sink_y = 0;
      req_sink_z = 0;
      req_source_x = 0;
      req_source_y = 0;
      req_source_z = 0;
      req_source_mass = 0;
      req_first_of_sink = 0;
      req_last_of_sink = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed pairs, first with no softening and no shift, then with softening and shifts.
      write_register(CSR_SOFTENING_SQ, 32'd0);
      write_register(CSR_UNUSED, 32'hFFFF_FFFF);
      send_simple(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1, 1);
      send_simple(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1);
      send_simple(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1);
      send_simple(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1);
      send_simple(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1, 1);
      send_simple(32'h0001_0000, 32'h0000_0000, 32'h0100_0000, 1, 0);
      send_simple(32'h0000_0000, 32'h0002_0000, 32'h0100_0000, 0, 0);
      send_simple(32'h0000_0000, 32'h0000_0000, 32'h0100_0000, 0, 1);
      send_simple(32'h0000_0100, 32'hFFFF_FF00, 32'h8000_0000, 0, 1);
      drain();
      write_register(CSR_SOFTENING_SQ, 32'hFFFF_FFFF);
      write_register(CSR_SHIFT_X, 32'h7FFF_FFFF);
      write_register(CSR_SHIFT_Y, 32'h8000_0000);
      write_register(CSR_SHIFT_Z, 32'h0000_0001);
      send_simple(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1);
      send_simple(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1);
      send_simple(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1, 1);
      drain();

      // Random phases, one idling pattern and one register setting each.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         case (phase)
            0: begin
               write_register(CSR_SOFTENING_SQ, 32'd0);
               write_register(CSR_SHIFT_X, 32'd0);
               write_register(CSR_SHIFT_Y, 32'd0);
               write_register(CSR_SHIFT_Z, 32'd0);
            end
            1: begin
               write_register(CSR_SOFTENING_SQ, $urandom_range(32'h0001_0000));
               write_register(CSR_SHIFT_X, random_coord(1));
               write_register(CSR_SHIFT_Y, random_coord(2));
               write_register(CSR_SHIFT_Z, random_coord(1));
            end
            2: begin
               write_register(CSR_SOFTENING_SQ, $urandom);
               write_register(CSR_SHIFT_X, $urandom);
               write_register(CSR_SHIFT_Y, 32'h8000_0000);
               write_register(CSR_SHIFT_Z, 32'h7FFF_FFFF);
            end
            default: begin
               write_register(CSR_SOFTENING_SQ, 32'h0000_0100);
               write_register(CSR_SHIFT_X, 32'hFFFF_0000);
               write_register(CSR_SHIFT_Y, 32'd0);
               write_register(CSR_SHIFT_Z, $urandom);
            end
         endcase
         random_sinks(420);
         drain();
      end

      $display("Covered %0d pairs and %0d sink totals, %0d of them saturated,",
               board.pairs_seen, board.totals_checked, board.saturated_seen);
      $display("over four idling patterns and six register settings.");
      if (board.mismatches == 0 && board.pending_totals.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d totals never arrived", board.mismatches,
                  board.pending_totals.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
